[design/ordered_list_append_delete_by_value_macros.svh]
// Assertion macros for the checker file of the ordered list block.
`ifndef ORDERED_LIST_APPEND_DELETE_BY_VALUE_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_BY_VALUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OLAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olad check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OLAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olad check failed");

`endif

[design/olad_pkg.sv]
// Types and codes shared by the ordered list block, its cells and its checker.
package olad_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // action codes
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] first_value;
        logic signed [VALUE_W-1:0] last_value;
    } rsp_word_t;

    // command broadcast from the control to every cell
    typedef struct packed {
        logic                      append_en;
        logic                      delete_en;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

[design/olad_cell.sv]
// One list position: holds an entry, compares it, and shifts toward the head.
module olad_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                              clk,
    input  olad_pkg::cell_cmd_t               cmd,
    input  logic [CW-1:0]                     count,
    input  logic signed [olad_pkg::VALUE_W-1:0] right_entry,
    input  logic                              found_in,
    input  logic signed [olad_pkg::VALUE_W-1:0] tail_in,
    output logic signed [olad_pkg::VALUE_W-1:0] entry,
    output logic                              found_out,
    output logic signed [olad_pkg::VALUE_W-1:0] tail_out
);

    localparam logic [CW-1:0] POS  = CW'(IDX);
    localparam logic [CW-1:0] NEXT = CW'(IDX + 1);

    logic signed [olad_pkg::VALUE_W-1:0] entry_reg;
    logic signed [olad_pkg::VALUE_W-1:0] entry_next;
    logic                                occupied;
    logic                                hit;
    logic                                is_tail;

    assign occupied = count > POS;
    assign is_tail  = count == NEXT;

    // Flag a match here and pass on any match nearer the head
    assign hit       = occupied && (entry_reg == cmd.value);
    assign found_out = found_in | hit;

    // Pass the tail entry down the row
    assign tail_out = is_tail ? entry_reg : tail_in;

    // Write on append into the free slot, pull from the right on delete
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.append_en && (count == POS))
        begin
            entry_next = cmd.value;
        end
        else if (cmd.delete_en && occupied && found_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[design/ordered_list_append_delete_by_value.sv]
// Ordered list of up to DEPTH signed 32-bit values with append at the tail and
// delete of the first entry that equals a given value. Every position is a cell
// that compares its entry with the request value and shifts from its right
// neighbor in the same cycle, so a request is fully applied at the edge that
// accepts it; the result word is built from the updated cells in the following
// cycle and is then registered onto rsp, later only while an earlier result
// word is held by rsp_stall. The
// block takes one request word per cycle for as long as the result side keeps
// taking words; a single pending stage plus the output register set that rate.
// Entries hold no reset value; only positions below the count are ever read.
module ordered_list_append_delete_by_value #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  olad_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output olad_pkg::rsp_word_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   pend_vld_reg;
    logic                   pend_vld_next;
    logic [1:0]             pend_status_reg;
    logic [1:0]             pend_status_next;
    logic                   rsp_vld_reg;
    logic                   rsp_vld_next;
    olad_pkg::rsp_word_t    rsp_word_reg;
    olad_pkg::rsp_word_t    rsp_word_next;

    logic                   accept;
    logic                   move;
    logic                   is_full;
    logic                   is_empty;
    logic                   found;
    logic [31:0]            count_wide;
    olad_pkg::cell_cmd_t    cmd;

    logic signed [olad_pkg::VALUE_W-1:0] entry_q    [DEPTH];
    logic                                found_chain[DEPTH+1];
    logic signed [olad_pkg::VALUE_W-1:0] tail_chain [DEPTH+1];

    // Handshake: hold the request while the pending result cannot advance
    assign move      = pend_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = pend_vld_reg && !move;
    assign accept    = req_valid && !req_stall;

    assign is_full  = count_reg == FULL_COUNT;
    assign is_empty = count_reg == '0;

    // Broadcast the command to the row
    assign cmd.append_en = accept && (req.action == olad_pkg::ACT_APPEND) && !is_full;
    assign cmd.delete_en = accept && (req.action == olad_pkg::ACT_DELETE);
    assign cmd.value     = req.value;

    assign found_chain[0] = 1'b0;
    assign tail_chain[0]  = '0;

    // Row of cells, head at position zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [olad_pkg::VALUE_W-1:0] right_entry;
        if (i < DEPTH - 1)
        begin : g_mid
            assign right_entry = entry_q[i+1];
        end
        else
        begin : g_end
            assign right_entry = entry_q[i];
        end

        olad_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .right_entry (right_entry),
            .found_in    (found_chain[i]),
            .tail_in     (tail_chain[i]),
            .entry       (entry_q[i]),
            .found_out   (found_chain[i+1]),
            .tail_out    (tail_chain[i+1])
        );
    end

    assign found = found_chain[DEPTH];

    // Decide status and new count
    always_comb
    begin
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        if (accept)
        begin
            if (req.action == olad_pkg::ACT_APPEND)
            begin
                if (is_full)
                begin
                    pend_status_next = olad_pkg::ST_FULL;
                end
                else
                begin
                    pend_status_next = olad_pkg::ST_DONE;
                    count_next       = count_reg + CW'(1);
                end
            end
            else if (is_empty)
            begin
                pend_status_next = olad_pkg::ST_EMPTY;
            end
            else if (!found)
            begin
                pend_status_next = olad_pkg::ST_NOTFOUND;
            end
            else
            begin
                pend_status_next = olad_pkg::ST_DONE;
                count_next       = count_reg - CW'(1);
            end
        end
    end

    // Track the pending result and the output slot
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        if (accept)
        begin
            pend_vld_next = 1'b1;
        end
        else if (move)
        begin
            pend_vld_next = 1'b0;
        end

        rsp_vld_next = rsp_vld_reg;
        if (move)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    // Build the result word from the updated cells
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        rsp_word_next.status      = pend_status_reg;
        rsp_word_next.entry_count = count_wide[olad_pkg::COUNT_W-1:0];
        rsp_word_next.first_value = is_empty ? '0 : entry_q[0];
        rsp_word_next.last_value  = tail_chain[DEPTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            pend_vld_reg    <= 1'b0;
            pend_status_reg <= olad_pkg::ST_DONE;
            rsp_vld_reg     <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            pend_vld_reg    <= pend_vld_next;
            pend_status_reg <= pend_status_next;
            rsp_vld_reg     <= rsp_vld_next;
        end
    end

    // Load the output word when the pending result advances
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_word_reg;

endmodule

[design/olad_checker.sv]
// Port-level checks for the ordered list block, bound to its top level.
`include "ordered_list_append_delete_by_value_macros.svh"

module olad_checker #(
    parameter int DEPTH = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input olad_pkg::rsp_word_t rsp
);

    localparam logic [olad_pkg::COUNT_W-1:0] FULL_COUNT = (olad_pkg::COUNT_W)'(DEPTH);

    logic rsp_empty;
    logic rsp_zero_ends;
    logic rsp_full_st;
    logic rsp_empty_st;

    assign rsp_empty     = rsp_valid && (rsp.entry_count == '0) && (DEPTH < 32);
    assign rsp_zero_ends = (rsp.first_value == '0) && (rsp.last_value == '0);
    assign rsp_full_st   = rsp_valid && (rsp.status == olad_pkg::ST_FULL);
    assign rsp_empty_st  = rsp_valid && (rsp.status == olad_pkg::ST_EMPTY);

    // A stalled result word holds
    `OLAD_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // An empty list reports zero head and tail
    `OLAD_ASSERT_IMP(a_empty_zero, rsp_empty, rsp_zero_ends)

    // A refused append leaves the list full
    `OLAD_ASSERT_IMP(a_full_count, rsp_full_st, rsp.entry_count == FULL_COUNT)

    // A delete on an empty list leaves it empty
    `OLAD_ASSERT_IMP(a_empty_count, rsp_empty_st, rsp.entry_count == '0)

endmodule

bind ordered_list_append_delete_by_value olad_checker #(
    .DEPTH (DEPTH)
) u_olad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
